@@ hdl/mkes_pkg.sv @@
// Shared types and constants of the matrix keypad event scanner.
package mkes_pkg;

   localparam int LANES        = 8;             // positions per column in the snapshot
   localparam int MATRIX_BITS  = LANES * LANES;
   localparam int KEYMAP_DEPTH = MATRIX_BITS;
   localparam int POS_W        = $clog2(KEYMAP_DEPTH);
   localparam int COORD_W      = 3;
   localparam int COUNT_W      = 4;
   localparam int GROUP_W      = 2;
   localparam int CODE_W       = 16;
   localparam int POLL_W       = 2;
   localparam int ACT_W        = 3;
   localparam int CSR_INDEX_W  = 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   localparam logic [POLL_W-1:0] POLL_IDLE  = 2'd0;
   localparam logic [POLL_W-1:0] POLL_SHORT = 2'd1;
   localparam logic [POLL_W-1:0] POLL_LONG  = 2'd2;

   localparam logic [ACT_W-1:0] GROUP_NONE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } walk_state_type;

   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [CODE_W-1:0]  code;
   } entry_data_type;

   typedef struct packed {
      logic           valid;
      entry_data_type data;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [POS_W-1:0] addr;
      logic             valid;
      entry_data_type   data;
   } keymap_write_type;

   typedef struct packed {
      logic               event_valid;
      logic [COORD_W-1:0] event_col;
      logic [COORD_W-1:0] event_row;
      logic [CODE_W-1:0]  key_code;
      logic               pressed;
      logic [POLL_W-1:0]  poll_mode;
      logic               last;
   } rsp_word_type;

endpackage

@@ hdl/mkes_if.sv @@
// Request and response channel interfaces of the keypad event scanner.
interface mkes_req_if;
   import mkes_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [MATRIX_BITS-1:0]   key_matrix;
   logic [COORD_W-1:0]       entry_col;
   logic [COORD_W-1:0]       entry_row;
   logic                     entry_valid;
   logic [GROUP_W-1:0]       entry_group;
   logic [CODE_W-1:0]        entry_code;

   modport source (
      output valid, operation, key_matrix, entry_col, entry_row, entry_valid,
             entry_group, entry_code,
      input  ready
   );
   modport sink (
      input  valid, operation, key_matrix, entry_col, entry_row, entry_valid,
             entry_group, entry_code,
      output ready
   );
endinterface

interface mkes_rsp_if;
   import mkes_pkg::*;
   logic               valid;
   logic               ready;
   logic               event_valid;
   logic [COORD_W-1:0] event_col;
   logic [COORD_W-1:0] event_row;
   logic [CODE_W-1:0]  key_code;
   logic               pressed;
   logic [POLL_W-1:0]  poll_mode;
   logic               last;

   modport source (
      output valid, event_valid, event_col, event_row, key_code, pressed,
             poll_mode, last,
      input  ready
   );
   modport sink (
      input  valid, event_valid, event_col, event_row, key_code, pressed,
             poll_mode, last,
      output ready
   );
endinterface

@@ hdl/matrix_keypad_event_scanner.sv @@
// Matrix keypad event scanner: a load word writes one keymap entry. A scan word
// captures the masked snapshot, walks every position column-major at one keymap read
// per cycle through the single memory read port and the shared group compare, unless
// the result side holds a word while another one waits, and then issues the final
// word carrying the poll mode. The request side is ready only between scans; the last
// result word may still wait in the output register while the next word is accepted.
// Keymap valid bits are flops cleared by reset, so no clearing pass follows reset.
module matrix_keypad_event_scanner #(
   parameter int MAX_COLS = 8,
   parameter int MAX_ROWS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mkes_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mkes_pkg::COUNT_W-1:0]      csr_wdata,
   mkes_req_if.sink                          req_ch,
   mkes_rsp_if.source                        rsp_ch
);
   import mkes_pkg::*;

   logic [COUNT_W-1:0]     cols_ff, cols_in;
   logic [COUNT_W-1:0]     rows_ff, rows_in;
   logic [COUNT_W-1:0]     ncols;
   logic [COUNT_W-1:0]     nrows;
   logic [MATRIX_BITS-1:0] use_mask;
   logic                   accept;
   logic                   start;
   logic                   idle;
   logic [POS_W-1:0]       rd_addr;
   entry_type              rd_entry;
   keymap_write_type       wr;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLS: cols_in = csr_wdata;
            CSR_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COUNT_RESET;
         rows_ff <= COUNT_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // clamp counts above the build limits
   assign ncols = (cols_ff > COUNT_W'(MAX_COLS)) ? COUNT_W'(MAX_COLS) : cols_ff;
   assign nrows = (rows_ff > COUNT_W'(MAX_ROWS)) ? COUNT_W'(MAX_ROWS) : rows_ff;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         for (int r = 0; r < LANES; r++) begin
            use_mask[c * LANES + r] = (COUNT_W'(c) < ncols) && (COUNT_W'(r) < nrows);
         end
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign start  = accept && (req_ch.operation == OP_SCAN);

   assign wr.we         = accept && (req_ch.operation == OP_LOAD);
   assign wr.addr       = {req_ch.entry_col, req_ch.entry_row};
   assign wr.valid      = req_ch.entry_valid;
   assign wr.data.group = req_ch.entry_group;
   assign wr.data.code  = req_ch.entry_code;

   assign req_ch.ready = idle;

   mkes_keymap u_keymap (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   mkes_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .scan_matrix (req_ch.key_matrix & use_mask),
      .scan_mask   (use_mask),
      .idle        (idle),
      .rd_addr     (rd_addr),
      .rd_entry    (rd_entry),
      .rsp         (rsp_ch)
   );

endmodule

@@ hdl/mkes_keymap.sv @@
// Keymap store: group and code in a memory, per-entry valid bits in flops.
module mkes_keymap (
   input  logic                      clock,
   input  logic                      reset,
   input  mkes_pkg::keymap_write_type wr,
   input  logic [mkes_pkg::POS_W-1:0] rd_addr,
   output mkes_pkg::entry_type        rd_entry
);
   import mkes_pkg::*;

   entry_data_type          key_mem [KEYMAP_DEPTH];
   logic [KEYMAP_DEPTH-1:0] valid_ff;
   logic [POS_W-1:0]        rd_addr_ff;
   entry_data_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         key_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= key_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   assign rd_entry.valid = valid_ff[rd_addr_ff];
   assign rd_entry.data  = rd_data_ff;

endmodule

@@ hdl/mkes_walker.sv @@
// Scan sequencer: walks every position, filters the changed ones by group, queues result words.
module mkes_walker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mkes_pkg::MATRIX_BITS-1:0] scan_matrix,
   input  logic [mkes_pkg::MATRIX_BITS-1:0] scan_mask,
   output logic                            idle,
   output logic [mkes_pkg::POS_W-1:0]      rd_addr,
   input  mkes_pkg::entry_type             rd_entry,
   mkes_rsp_if.source                      rsp
);
   import mkes_pkg::*;

   walk_state_type         state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [MATRIX_BITS-1:0] now_ff, now_in;
   logic [MATRIX_BITS-1:0] changed_ff, changed_in;
   logic [MATRIX_BITS-1:0] prev_ff, prev_in;
   logic [ACT_W-1:0]       act_ff, act_in;
   logic                   spur_ff, spur_in;
   logic                   pend_vld_ff, pend_vld_in;
   rsp_word_type           pend_ff, pend_in;
   logic                   out_vld_ff, out_vld_in;
   rsp_word_type           out_ff, out_in;

   logic                   out_free;
   logic                   stall;
   logic                   at_end;
   logic                   chg;
   logic                   grp_ok;
   logic                   hit;
   logic [POLL_W-1:0]      mode;

   assign out_free = !out_vld_ff || rsp.ready;
   assign stall    = pend_vld_ff && !out_free;
   assign at_end   = (pos_ff == POS_W'(KEYMAP_DEPTH - 1));
   assign chg      = changed_ff[pos_ff];
   // shared group compare, one position a cycle unless the walk stalls
   assign grp_ok   = (act_ff == GROUP_NONE) || (act_ff == {1'b0, rd_entry.data.group});
   assign hit      = chg && rd_entry.valid && grp_ok;
   assign mode     = (now_ff == '0) ? POLL_IDLE : (spur_ff ? POLL_LONG : POLL_SHORT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!stall && at_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in      = pos_ff;
      now_in      = now_ff;
      changed_in  = changed_ff;
      prev_in     = prev_ff;
      act_in      = act_ff;
      spur_in     = spur_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp.ready;
      out_in      = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in      = scan_matrix;
               // compare only over the positions in use now
               changed_in  = (scan_matrix ^ prev_ff) & scan_mask;
               prev_in     = scan_matrix;
               pos_in      = '0;
               spur_in     = 1'b0;
               pend_vld_in = 1'b0;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               pos_in = pos_ff + POS_W'(1);
               if (chg && !rd_entry.valid) spur_in = 1'b1;
               if (hit) begin
                  act_in = {1'b0, rd_entry.data.group};
                  // hand the held word on; it is not the final one
                  if (pend_vld_ff) begin
                     out_vld_in = 1'b1;
                     out_in     = pend_ff;
                  end
                  pend_vld_in         = 1'b1;
                  pend_in.event_valid = 1'b1;
                  pend_in.event_col   = pos_ff[POS_W-1 -: COORD_W];
                  pend_in.event_row   = pos_ff[COORD_W-1:0];
                  pend_in.key_code    = rd_entry.data.code;
                  pend_in.pressed     = now_ff[pos_ff];
                  pend_in.poll_mode   = POLL_IDLE;
                  pend_in.last        = 1'b0;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_vld_in       = 1'b1;
               out_in           = pend_vld_ff ? pend_ff : '0;
               out_in.poll_mode = mode;
               out_in.last      = 1'b1;
               pend_vld_in      = 1'b0;
               // release the group once no key is held
               if (now_ff == '0) act_in = GROUP_NONE;
            end
         end
         default: begin
            pend_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prev_ff     <= '0;
         act_ff      <= GROUP_NONE;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prev_ff     <= prev_in;
         act_ff      <= act_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      now_ff     <= now_in;
      changed_ff <= changed_in;
      spur_ff    <= spur_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign idle    = (state_ff == ST_IDLE);
   assign rd_addr = pos_in;

   assign rsp.valid       = out_vld_ff;
   assign rsp.event_valid = out_ff.event_valid;
   assign rsp.event_col   = out_ff.event_col;
   assign rsp.event_row   = out_ff.event_row;
   assign rsp.key_code    = out_ff.key_code;
   assign rsp.pressed     = out_ff.pressed;
   assign rsp.poll_mode   = out_ff.poll_mode;
   assign rsp.last        = out_ff.last;

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (out_vld_ff && out_ff.last))
      else $error("final word not flagged last");

   a_pend_group: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (act_ff != GROUP_NONE))
      else $error("held event without an active group");

   a_mid_word: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.last) |-> (out_ff.event_valid && out_ff.poll_mode == POLL_IDLE))
      else $error("non-final word malformed");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_WALK && pos_ff == '0))
      else $error("scan did not start at position zero");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the matrix keypad event scanner with its scoreboard.
module tb;
   import mkes_pkg::*;

   localparam int MAX_COLS       = 8;
   localparam int MAX_ROWS       = 8;
   localparam int MAX_GAP        = 14;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic                   operation;
      logic [MATRIX_BITS-1:0] key_matrix;
      logic [COORD_W-1:0]     entry_col;
      logic [COORD_W-1:0]     entry_row;
      logic                   entry_valid;
      logic [GROUP_W-1:0]     entry_group;
      logic [CODE_W-1:0]      entry_code;
   } req_word_type;

   class keypad_scoreboard;
      rsp_word_type           pending_events[$];
      entry_type              keymap[KEYMAP_DEPTH];
      logic [MATRIX_BITS-1:0] prev_matrix;
      logic [ACT_W-1:0]       active_group;
      logic [COUNT_W-1:0]     col_count;
      logic [COUNT_W-1:0]     row_count;
      int                     mismatches;

      function new();
         foreach (keymap[i]) keymap[i] = '0;
         prev_matrix  = '0;
         active_group = GROUP_NONE;
         col_count    = COUNT_RESET;
         row_count    = COUNT_RESET;
         mismatches   = 0;
      endfunction

      function void set_count(logic [CSR_INDEX_W-1:0] index, logic [COUNT_W-1:0] value);
         if (index == CSR_COLS)
            col_count = value;
         else
            row_count = value;
      endfunction

      // Note an accepted request word and queue the events it must cause.
      function void predict_word(req_word_type w);
         int                     ncols;
         int                     nrows;
         int                     pos;
         bit                     spurious;
         logic [MATRIX_BITS-1:0] mask;
         logic [MATRIX_BITS-1:0] now;
         logic [MATRIX_BITS-1:0] changed;
         logic [POLL_W-1:0]      mode;
         rsp_word_type           found[$];
         rsp_word_type           word;
         if (w.operation == OP_LOAD) begin
            pos = {w.entry_col, w.entry_row};
            keymap[pos].valid      = w.entry_valid;
            keymap[pos].data.group = w.entry_group;
            keymap[pos].data.code  = w.entry_code;
            return;
         end
         ncols    = (col_count > MAX_COLS) ? MAX_COLS : col_count;
         nrows    = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
         spurious = 1'b0;
         mask     = '0;
         for (int c = 0; c < ncols; c++)
            for (int r = 0; r < nrows; r++)
               mask[c * LANES + r] = 1'b1;
         now     = w.key_matrix & mask;
         changed = now ^ prev_matrix;
         for (int c = 0; c < ncols; c++) begin
            for (int r = 0; r < nrows; r++) begin
               pos = c * LANES + r;
               if (!changed[pos])
                  continue;
               if (!keymap[pos].valid) begin
                  spurious = 1'b1;
                  continue;
               end
               // drop keys of another group while one is latched
               if (active_group != GROUP_NONE &&
                   active_group != {1'b0, keymap[pos].data.group})
                  continue;
               active_group     = {1'b0, keymap[pos].data.group};
               word             = '0;
               word.event_valid = 1'b1;
               word.event_col   = COORD_W'(c);
               word.event_row   = COORD_W'(r);
               word.key_code    = keymap[pos].data.code;
               word.pressed     = now[pos];
               found.push_back(word);
            end
         end
         prev_matrix = now;
         if (now != '0)
            mode = spurious ? POLL_LONG : POLL_SHORT;
         else begin
            mode         = POLL_IDLE;
            active_group = GROUP_NONE;
         end
         if (found.size() == 0) begin
            word = '0;
            found.push_back(word);
         end
         foreach (found[i]) begin
            word = found[i];
            if (i == found.size() - 1) begin
               word.poll_mode = mode;
               word.last      = 1'b1;
            end
            pending_events.push_back(word);
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected word: ev=%0d col=%0d row=%0d code=%h pr=%0d poll=%0d last=%0d",
                        got.event_valid, got.event_col, got.event_row, got.key_code,
                        got.pressed, got.poll_mode, got.last);
            return;
         end
         want = pending_events.pop_front();
         if (got.event_valid !== want.event_valid || got.event_col !== want.event_col ||
             got.event_row !== want.event_row || got.key_code !== want.key_code ||
             got.pressed !== want.pressed || got.poll_mode !== want.poll_mode ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("mismatch at %0t", $realtime);
               $display("  expected ev=%0d col=%0d row=%0d code=%h pr=%0d poll=%0d last=%0d",
                        want.event_valid, want.event_col, want.event_row, want.key_code,
                        want.pressed, want.poll_mode, want.last);
               $display("  actual   ev=%0d col=%0d row=%0d code=%h pr=%0d poll=%0d last=%0d",
                        got.event_valid, got.event_col, got.event_row, got.key_code,
                        got.pressed, got.poll_mode, got.last);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_wdata;
   logic [MATRIX_BITS-1:0] last_snapshot;
   bit                     steady_flow;
   keypad_scoreboard       sb;

   mkes_req_if req_if();
   mkes_rsp_if rsp_if();

   matrix_keypad_event_scanner #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Present one word and hold it until accepted; valid stays high for a back-to-back word.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= w.operation;
      req_if.key_matrix  <= w.key_matrix;
      req_if.entry_col   <= w.entry_col;
      req_if.entry_row   <= w.entry_row;
      req_if.entry_valid <= w.entry_valid;
      req_if.entry_group <= w.entry_group;
      req_if.entry_code  <= w.entry_code;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.predict_word(w);
   endtask

   task automatic load_entry(input int col, input int row, input bit valid, input int group,
                             input int code);
      req_word_type w;
      w.operation   = OP_LOAD;
      w.key_matrix  = {$urandom, $urandom};
      w.entry_col   = COORD_W'(col);
      w.entry_row   = COORD_W'(row);
      w.entry_valid = valid;
      w.entry_group = GROUP_W'(group);
      w.entry_code  = CODE_W'(code);
      send_word(w);
   endtask

   task automatic scan_keys(input logic [MATRIX_BITS-1:0] snap);
      req_word_type w;
      w.operation   = OP_SCAN;
      w.key_matrix  = snap;
      w.entry_col   = COORD_W'($urandom);
      w.entry_row   = COORD_W'($urandom);
      w.entry_valid = 1'($urandom);
      w.entry_group = GROUP_W'($urandom);
      w.entry_code  = CODE_W'($urandom);
      last_snapshot = snap;
      send_word(w);
   endtask

   task automatic set_scan_size(input logic [COUNT_W-1:0] cols,
                                input logic [COUNT_W-1:0] rows);
      csr_we    <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_count(CSR_COLS, cols);
      sb.set_count(CSR_ROWS, rows);
   endtask

   // Drop valid, drain every expected word, then let the walk settle.
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Keymap loads and small edits of the held keys, with releases, noise, column rewrites and full presses mixed in.
   task automatic run_random(input int count);
      int                     pick;
      logic [MATRIX_BITS-1:0] snap;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(15) == 0)
            steady_flow = !steady_flow;
         pick = $urandom_range(99);
         if (pick < 25) begin
            load_entry($urandom_range(7), $urandom_range(7), $urandom_range(99) < 85,
                       $urandom_range(1) ? 0 : $urandom_range(3), $urandom_range(16'hffff));
         end else begin
            snap = last_snapshot;
            if (pick < 65)
               repeat ($urandom_range(1, 3)) snap[$urandom_range(MATRIX_BITS - 1)] ^= 1'b1;
            else if (pick < 75)
               snap = '0;
            else if (pick < 87)
               snap = {$urandom, $urandom};
            else if (pick < 95)
               snap[$urandom_range(7) * LANES +: LANES] = LANES'($urandom);
            else
               snap = '1;
            scan_keys(snap);
         end
      end
   endtask

   initial begin
      int stall;
      rsp_word_type got;
      wait (reset === 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(MAX_GAP);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.event_valid = rsp_if.event_valid;
         got.event_col   = rsp_if.event_col;
         got.event_row   = rsp_if.event_row;
         got.key_code    = rsp_if.key_code;
         got.pressed     = rsp_if.pressed;
         got.poll_mode   = rsp_if.poll_mode;
         got.last        = rsp_if.last;
         sb.check_word(got);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset === 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      sb                 = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_COLS;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.operation   = OP_LOAD;
      req_if.key_matrix  = '0;
      req_if.entry_col   = '0;
      req_if.entry_row   = '0;
      req_if.entry_valid = 1'b0;
      req_if.entry_group = '0;
      req_if.entry_code  = '0;
      rsp_if.ready       = 1'b0;
      last_snapshot      = '0;
      steady_flow        = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset size of eight by eight
      scan_keys('0);
      scan_keys(64'h0000_0000_0000_0100);   // unmapped key held: long poll, no event
      scan_keys('0);                        // unmapped release back to idle
      load_entry(0, 0, 1'b1, 0, 16'hffff);
      load_entry(7, 7, 1'b1, 3, 16'h0000);
      load_entry(3, 4, 1'b1, 3, 16'h1234);
      load_entry(2, 1, 1'b1, 1, 16'ha5a5);
      load_entry(7, 7, 1'b1, 3, 16'hbeef);  // overwrite a loaded position
      load_entry(5, 5, 1'b0, 2, 16'h5555);  // invalid entry with live fields
      scan_keys('1);                        // first group latches, others filtered
      scan_keys(~64'h1);                    // release of the latched key alone
      scan_keys('0);
      scan_keys((64'h1 << 28) | (64'h1 << 63));
      scan_keys(64'h1 << 63);
      scan_keys('0);
      scan_keys(64'h5555_5555_5555_5555);
      scan_keys(64'haaaa_aaaa_aaaa_aaaa);
      scan_keys('0);
      finish_phase();

      set_scan_size(4'd1, 4'd1);
      run_random(20);
      finish_phase();
      set_scan_size(4'd0, 4'd8);
      run_random(12);
      finish_phase();
      set_scan_size(4'd8, 4'd0);
      run_random(12);
      finish_phase();
      set_scan_size(4'd15, 4'd15);
      run_random(30);
      finish_phase();
      set_scan_size(4'd3, 4'd5);
      run_random(30);
      finish_phase();

      // map every position into one group so a full press yields the most words
      set_scan_size(4'd8, 4'd8);
      for (int pos = 0; pos < KEYMAP_DEPTH; pos++)
         load_entry(pos / LANES, pos % LANES, 1'b1, 2, $urandom_range(16'hffff));
      scan_keys('0);
      scan_keys('1);
      scan_keys('0);
      run_random(30);
      finish_phase();

      set_scan_size(4'd7, 4'd2);
      run_random(30);
      finish_phase();

      if (sb.mismatches == 0 && sb.pending_events.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
